[sv/labelled_packet_deframer_top_macros.svh]
// Assertion macros shared by the deframer modules.
`ifndef LABELLED_PACKET_DEFRAMER_TOP_MACROS_SVH
`define LABELLED_PACKET_DEFRAMER_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define LPD_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deframer invariant violated");

// When the antecedent holds, the consequent must hold in the cycle after.
`define LPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer sequence violated");

`endif

[sv/lpd_pkg.sv]
// Types, constants and codes shared by the labelled packet deframer.
package lpd_pkg;

    localparam int MAX_PAYLOAD = 512;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 16;
    localparam int IDX_W  = 9;
    localparam int KEEP_W = 10;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);

    localparam int TOKQ_DEPTH = 4;
    localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CW    = $clog2(TOKQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [DATA_W-1:0] START_BYTE = 8'h7E;
    localparam logic [DATA_W-1:0] END_BYTE   = 8'hE7;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    localparam logic RK_PAYLOAD = 1'b0;
    localparam logic RK_STATUS  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_GOOD     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_END  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd2;
    localparam logic [STAT_W-1:0] STAT_TIMEOUT  = 2'd3;

    localparam int  APB_DATA_W = 32;
    localparam int  APB_ADDR_W = 3;
    localparam logic REG_WANTED_LABEL = 1'b0;
    localparam logic REG_KEEP_COUNT   = 1'b1;

    // One classified input word as the front hands it to the back.
    typedef struct packed {
        logic              timeout;
        logic              is_start;
        logic              is_end;
        logic              is_label;
        logic [DATA_W-1:0] data;
    } lpd_token_t;

    typedef struct packed {
        logic              result_kind;
        logic [DATA_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              keep;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  packet_length;
    } lpd_result_t;

endpackage

[sv/lpd_front.sv]
// Front end: classifies incoming words and queues them for the packet sequencer.
`include "labelled_packet_deframer_top_macros.svh"
module lpd_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      kind,
    input  logic [lpd_pkg::DATA_W-1:0] rx_byte,
    input  logic [lpd_pkg::DATA_W-1:0] wanted_label,
    output logic                      tok_valid,
    output lpd_pkg::lpd_token_t       tok,
    input  logic                      tok_pop
);
    import lpd_pkg::*;

    lpd_token_t         mem [TOKQ_DEPTH];
    lpd_token_t         new_tok;
    logic [TOKQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TOKQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TOKQ_CW-1:0] count_reg, count_next;
    logic               wr_en;
    logic               rd_en;

    assign full      = (count_reg == TOKQ_CW'(TOKQ_DEPTH));
    assign tok_valid = (count_reg != '0);
    assign tok       = mem[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = tok_pop && tok_valid;

    always_comb
    begin
        new_tok.timeout  = (kind == KIND_TIMEOUT);
        new_tok.is_start = (rx_byte == START_BYTE);
        new_tok.is_end   = (rx_byte == END_BYTE);
        new_tok.is_label = (rx_byte == wanted_label);
        new_tok.data     = rx_byte;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == TOKQ_AW'(TOKQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == TOKQ_AW'(TOKQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + TOKQ_CW'(wr_en) - TOKQ_CW'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= new_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LPD_ASSERT_HOLDS(a_tokq_count_bound, count_reg <= TOKQ_CW'(TOKQ_DEPTH))

endmodule

[sv/lpd_back.sv]
// Back end: packet sequencer that turns classified words into results.
`include "labelled_packet_deframer_top_macros.svh"
module lpd_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tok_valid,
    input  lpd_pkg::lpd_token_t        tok,
    output logic                       tok_pop,
    input  logic [lpd_pkg::KEEP_W-1:0] keep_count,
    input  logic                       res_full,
    output logic                       res_valid,
    output lpd_pkg::lpd_result_t       res
);
    import lpd_pkg::*;

    typedef enum logic [5:0] {
        ST_HUNT   = 6'b000001,
        ST_LABEL  = 6'b000010,
        ST_LEN_LO = 6'b000100,
        ST_LEN_HI = 6'b001000,
        ST_DATA   = 6'b010000,
        ST_END    = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] full_len;
    logic [LEN_W-1:0] idx_ext;
    logic [LEN_W-1:0] idx_inc_ext;
    logic             data_bounds_ok;

    assign tok_pop     = tok_valid && !res_full;
    assign full_len    = {tok.data, len_reg[DATA_W-1:0]};
    assign idx_ext     = LEN_W'(cnt_reg);
    assign idx_inc_ext = idx_ext + 1'b1;

    assign data_bounds_ok = (state_reg != ST_DATA)
                            || ((idx_ext < len_reg) && (len_reg <= LEN_W'(MAX_PAYLOAD)));

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;

        res.result_kind   = RK_STATUS;
        res.payload_byte  = '0;
        res.byte_index    = '0;
        res.keep          = 1'b0;
        res.status        = STAT_GOOD;
        res.packet_length = len_reg;

        if (tok_pop)
        begin
            if (tok.timeout)
            begin
                res_valid  = 1'b1;
                res.status = STAT_TIMEOUT;
                state_next = ST_HUNT;
                len_next   = '0;
                cnt_next   = '0;
            end
            else
            begin
                case (state_reg)
                    ST_HUNT:
                    begin
                        if (tok.is_start)
                        begin
                            state_next = ST_LABEL;
                            len_next   = '0;
                            cnt_next   = '0;
                        end
                    end
                    ST_LABEL:
                    begin
                        // A matching label wins even when the label is the start byte.
                        if (tok.is_label)
                        begin
                            state_next = ST_LEN_LO;
                        end
                        else if (tok.is_start)
                        begin
                            state_next = ST_LABEL;
                        end
                        else
                        begin
                            state_next = ST_HUNT;
                        end
                    end
                    ST_LEN_LO:
                    begin
                        len_next   = LEN_W'(tok.data);
                        state_next = ST_LEN_HI;
                    end
                    ST_LEN_HI:
                    begin
                        cnt_next = '0;
                        if (full_len > LEN_W'(MAX_PAYLOAD))
                        begin
                            res_valid         = 1'b1;
                            res.status        = STAT_TOO_LONG;
                            res.packet_length = full_len;
                            state_next        = ST_HUNT;
                            len_next          = '0;
                        end
                        else
                        begin
                            len_next   = full_len;
                            state_next = (full_len == '0) ? ST_END : ST_DATA;
                        end
                    end
                    ST_DATA:
                    begin
                        res_valid        = 1'b1;
                        res.result_kind  = RK_PAYLOAD;
                        res.payload_byte = tok.data;
                        res.byte_index   = idx_ext[IDX_W-1:0];
                        res.keep         = (idx_ext < LEN_W'(keep_count));
                        cnt_next         = cnt_reg + 1'b1;
                        if (idx_inc_ext >= len_reg)
                        begin
                            state_next = ST_END;
                        end
                    end
                    ST_END:
                    begin
                        res_valid  = 1'b1;
                        res.status = tok.is_end ? STAT_GOOD : STAT_BAD_END;
                        state_next = ST_HUNT;
                        len_next   = '0;
                        cnt_next   = '0;
                    end
                    default:
                    begin
                        state_next = ST_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    `LPD_ASSERT_NEXT(a_timeout_to_hunt, tok_pop && tok.timeout, state_reg == ST_HUNT)
    `LPD_ASSERT_HOLDS(a_data_count_bound, data_bounds_ok)
    `LPD_ASSERT_HOLDS(a_result_needs_word, !res_valid || tok_pop)

endmodule

[sv/lpd_outq.sv]
// Result queue that holds finished words until the consumer pops them.
`include "labelled_packet_deframer_top_macros.svh"
module lpd_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lpd_pkg::lpd_result_t din,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output lpd_pkg::lpd_result_t dout
);
    import lpd_pkg::*;

    lpd_result_t        mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0] count_reg, count_next;
    logic               wr_en;
    logic               rd_en;

    assign full  = (count_reg == OUTQ_CW'(OUTQ_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + OUTQ_CW'(wr_en) - OUTQ_CW'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LPD_ASSERT_NEXT(a_outq_filled, wr_en, !empty)

endmodule

[sv/labelled_packet_deframer_top.sv]
// Labelled packet deframer: takes one word per cycle unless full and delivers
// at most one result word for it. A word accepted at one clock edge is
// classified into a four-entry queue and then handled by the packet sequencer,
// which retires one word per cycle unless the result queue is full, into a
// two-entry result queue that drives the result ports; input and result sides
// stall independently. The sustained rate is one word per cycle without
// stalls, set by the sequencer, which updates its phase, length and byte count
// once for each word. Registers: wanted_label at address 0 (reset 3) and
// keep_count at address 4 (reset 5); write them only while the block is idle.
module labelled_packet_deframer_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           kind,
    input  logic [lpd_pkg::DATA_W-1:0]     rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic                           result_kind,
    output logic [lpd_pkg::DATA_W-1:0]     payload_byte,
    output logic [lpd_pkg::IDX_W-1:0]      byte_index,
    output logic                           keep,
    output logic [lpd_pkg::STAT_W-1:0]     status,
    output logic [lpd_pkg::LEN_W-1:0]      packet_length,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lpd_pkg::*;

    logic [DATA_W-1:0] wanted_label_reg, wanted_label_next;
    logic [KEEP_W-1:0] keep_count_reg, keep_count_next;
    logic              cfg_wr;
    logic              reg_sel;

    logic              tok_valid;
    lpd_token_t        tok;
    logic              tok_pop;
    logic              res_valid;
    lpd_result_t       res;
    logic              res_full;
    lpd_result_t       dout;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        wanted_label_next = wanted_label_reg;
        keep_count_next   = keep_count_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_WANTED_LABEL: wanted_label_next = pwdata[DATA_W-1:0];
                REG_KEEP_COUNT:   keep_count_next   = pwdata[KEEP_W-1:0];
                default:          wanted_label_next = wanted_label_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WANTED_LABEL: prdata = APB_DATA_W'(wanted_label_reg);
            REG_KEEP_COUNT:   prdata = APB_DATA_W'(keep_count_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_label_reg <= DATA_W'(3);
            keep_count_reg   <= KEEP_W'(5);
        end
        else
        begin
            wanted_label_reg <= wanted_label_next;
            keep_count_reg   <= keep_count_next;
        end
    end

    lpd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .wanted_label (wanted_label_reg),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .tok_pop      (tok_pop)
    );

    lpd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (tok_valid),
        .tok        (tok),
        .tok_pop    (tok_pop),
        .keep_count (keep_count_reg),
        .res_full   (res_full),
        .res_valid  (res_valid),
        .res        (res)
    );

    lpd_outq u_outq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .dout  (dout)
    );

    assign result_kind   = dout.result_kind;
    assign payload_byte  = dout.payload_byte;
    assign byte_index    = dout.byte_index;
    assign keep          = dout.keep;
    assign status        = dout.status;
    assign packet_length = dout.packet_length;

endmodule
